[rtl/bcrf_pkg.sv]
// ----------------------------------------------------------------------------
// Burst coalescing request framer: shared package
// Types, control word layout, step addresses and register indexes.
// ----------------------------------------------------------------------------
package bcrf_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int UPC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_CODE  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] WRITE_CODE_RESET = 8'd0;
    localparam logic [CFG_DATA_W-1:0] READ_CODE_RESET  = 8'd1;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t STEP_WAIT     = 4'd0;
    localparam upc_t STEP_DISPATCH = 4'd1;
    localparam upc_t STEP_MATCH    = 4'd2;
    localparam upc_t STEP_BREAK    = 4'd3;
    localparam upc_t STEP_OPEN     = 4'd4;
    localparam upc_t STEP_APPEND   = 4'd5;
    localparam upc_t STEP_CHECK    = 4'd6;
    localparam upc_t STEP_OPCODE   = 4'd7;
    localparam upc_t STEP_ID       = 4'd8;
    localparam upc_t STEP_BASE     = 4'd9;
    localparam upc_t STEP_LEN      = 4'd10;
    localparam upc_t STEP_DATA     = 4'd11;
    localparam upc_t STEP_CLOSE    = 4'd12;
    localparam upc_t STEP_REOPEN   = 4'd13;

    typedef enum logic [2:0] {
        EMIT_NONE   = 3'd0,
        EMIT_OPCODE = 3'd1,
        EMIT_ID     = 3'd2,
        EMIT_BASE   = 3'd3,
        EMIT_LEN    = 3'd4,
        EMIT_DATA   = 3'd5
    } emit_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CAPTURE = 3'd1,
        ACT_OPEN    = 3'd2,
        ACT_APPEND  = 3'd3,
        ACT_BREAK   = 3'd4,
        ACT_CLOSE   = 3'd5,
        ACT_REOPEN  = 3'd6
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER     = 4'd0,
        C_ALWAYS    = 4'd1,
        C_NO_INPUT  = 4'd2,
        C_NOT_OPEN  = 4'd3,
        C_MATCH     = 4'd4,
        C_NO_SEND   = 4'd5,
        C_NOT_WRITE = 4'd6,
        C_DATA_MORE = 4'd7,
        C_NO_REOPEN = 4'd8
    } cond_t;

    typedef struct packed {
        logic      take_in;
        act_t      act;
        emit_sel_t emit;
        cond_t     cond;
        upc_t      target;
    } ucode_t;

    typedef struct packed {
        ucode_t word;
        logic   go;
    } ctrl_t;

    typedef struct packed {
        logic open;
        logic match;
        logic send_needed;
        logic is_write;
        logic data_more;
        logic reopen;
        logic out_free;
    } status_t;

endpackage

[rtl/bcrf_ucode_rom.sv]
// ----------------------------------------------------------------------------
// Burst coalescing request framer: microcode store
// Read-only table holding one control word for each sequencer step.
// ----------------------------------------------------------------------------
module bcrf_ucode_rom
(
    input  bcrf_pkg::upc_t   upc,
    output bcrf_pkg::ucode_t word
);
    import bcrf_pkg::*;

    always_comb
    begin
        word = '{take_in: 1'b0, act: ACT_NONE, emit: EMIT_NONE,
                 cond: C_NEVER, target: STEP_WAIT};
        case (upc)
            STEP_WAIT:
            begin
                word.take_in = 1'b1;
                word.act     = ACT_CAPTURE;
                word.cond    = C_NO_INPUT;
                word.target  = STEP_WAIT;
            end
            STEP_DISPATCH:
            begin
                word.cond   = C_NOT_OPEN;
                word.target = STEP_OPEN;
            end
            STEP_MATCH:
            begin
                word.cond   = C_MATCH;
                word.target = STEP_APPEND;
            end
            STEP_BREAK:
            begin
                word.act    = ACT_BREAK;
                word.cond   = C_ALWAYS;
                word.target = STEP_OPCODE;
            end
            STEP_OPEN:
            begin
                word.act    = ACT_OPEN;
                word.cond   = C_ALWAYS;
                word.target = STEP_CHECK;
            end
            STEP_APPEND:
            begin
                word.act = ACT_APPEND;
            end
            STEP_CHECK:
            begin
                word.cond   = C_NO_SEND;
                word.target = STEP_WAIT;
            end
            STEP_OPCODE:
            begin
                word.emit = EMIT_OPCODE;
            end
            STEP_ID:
            begin
                word.emit = EMIT_ID;
            end
            STEP_BASE:
            begin
                word.emit = EMIT_BASE;
            end
            STEP_LEN:
            begin
                word.emit   = EMIT_LEN;
                word.cond   = C_NOT_WRITE;
                word.target = STEP_CLOSE;
            end
            STEP_DATA:
            begin
                word.emit   = EMIT_DATA;
                word.cond   = C_DATA_MORE;
                word.target = STEP_DATA;
            end
            STEP_CLOSE:
            begin
                word.act    = ACT_CLOSE;
                word.cond   = C_NO_REOPEN;
                word.target = STEP_WAIT;
            end
            STEP_REOPEN:
            begin
                word.act    = ACT_REOPEN;
                word.cond   = C_ALWAYS;
                word.target = STEP_OPEN;
            end
            default:
            begin
                word.cond   = C_ALWAYS;
                word.target = STEP_WAIT;
            end
        endcase
    end

endmodule

[rtl/bcrf_sequencer.sv]
// ----------------------------------------------------------------------------
// Burst coalescing request framer: step sequencer
// Step counter with conditional jumps; holds the step while the output
// register cannot take a word.
// ----------------------------------------------------------------------------
module bcrf_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bcrf_pkg::status_t status,
    output bcrf_pkg::ctrl_t   ctrl
);
    import bcrf_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t word;
    logic   go;
    logic   taken;

    bcrf_ucode_rom u_rom
    (
        .upc  (upc_reg),
        .word (word)
    );

    assign go = (word.emit == EMIT_NONE) || status.out_free;

    always_comb
    begin
        case (word.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_INPUT:  taken = !in_valid;
            C_NOT_OPEN:  taken = !status.open;
            C_MATCH:     taken = status.match;
            C_NO_SEND:   taken = !status.send_needed;
            C_NOT_WRITE: taken = !status.is_write;
            C_DATA_MORE: taken = status.data_more;
            C_NO_REOPEN: taken = !status.reopen;
            default:     taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!go)
        begin
            upc_next = upc_reg;
        end
        else if (taken)
        begin
            upc_next = word.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.word = word;
    assign ctrl.go   = go;

endmodule

[rtl/bcrf_datapath.sv]
// ----------------------------------------------------------------------------
// Burst coalescing request framer: datapath
// Command holding register, open burst state, data buffer, transaction id,
// opcode registers and the output word register.
// ----------------------------------------------------------------------------
module bcrf_datapath
#(
    parameter int MAX_BURST  = 8,
    parameter int ADDR_WIDTH = 32,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bcrf_pkg::ctrl_t                      ctrl,
    input  logic                                 in_valid,
    input  logic [bcrf_pkg::WORD_W-1:0]          address,
    input  logic [bcrf_pkg::WORD_W-1:0]          write_data,
    input  logic                                 is_write,
    input  logic                                 more_waiting,
    input  logic                                 cfg_write,
    input  logic [bcrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcrf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 out_ready,
    output bcrf_pkg::status_t                    status,
    output logic                                 out_valid,
    output logic [bcrf_pkg::WORD_W-1:0]          net_word,
    output logic                                 last_word
);
    import bcrf_pkg::*;

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int IDX_W = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    logic [ADDR_WIDTH-1:0] item_addr_reg;
    logic [DATA_WIDTH-1:0] item_data_reg;
    logic                  item_wr_reg;
    logic                  item_more_reg;

    logic                  burst_open_reg;
    logic [ADDR_WIDTH-1:0] burst_base_reg;
    logic                  burst_is_write_reg;
    logic [CNT_W-1:0]      burst_count_reg;
    logic [DATA_WIDTH-1:0] burst_data_reg [MAX_BURST];
    logic [IDX_W-1:0]      data_idx_reg;
    logic [WORD_W-1:0]     next_id_reg;
    logic                  reopen_reg;

    logic [CFG_DATA_W-1:0] write_code_reg;
    logic [CFG_DATA_W-1:0] read_code_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     net_word_reg;
    logic                  last_word_reg;

    logic [ADDR_WIDTH-1:0] expect_addr;
    logic                  data_more;
    logic                  followup;
    logic                  final_burst;
    logic                  emit_fire;
    logic [WORD_W-1:0]     word_next;
    logic                  last_next;
    logic                  capture;

    assign capture     = (ctrl.word.act == ACT_CAPTURE) && in_valid;
    assign emit_fire   = ctrl.go && (ctrl.word.emit != EMIT_NONE);
    assign expect_addr = burst_base_reg + ADDR_WIDTH'(burst_count_reg);
    assign data_more   = (CNT_W'(data_idx_reg) + CNT_W'(1)) != burst_count_reg;
    assign followup    = !item_more_reg || (MAX_BURST == 1);
    assign final_burst = !(reopen_reg && followup);

    assign status.open        = burst_open_reg;
    assign status.match       = (item_wr_reg == burst_is_write_reg)
                                && (item_addr_reg == expect_addr)
                                && (burst_count_reg < CNT_W'(MAX_BURST));
    assign status.send_needed = (burst_count_reg >= CNT_W'(MAX_BURST)) || !item_more_reg;
    assign status.is_write    = burst_is_write_reg;
    assign status.data_more   = data_more;
    assign status.reopen      = reopen_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        word_next = '0;
        last_next = 1'b0;
        case (ctrl.word.emit)
            EMIT_OPCODE:
            begin
                word_next = burst_is_write_reg ? WORD_W'(write_code_reg)
                                               : WORD_W'(read_code_reg);
            end
            EMIT_ID:
            begin
                word_next = next_id_reg;
            end
            EMIT_BASE:
            begin
                word_next = WORD_W'(burst_base_reg);
            end
            EMIT_LEN:
            begin
                word_next = WORD_W'(burst_count_reg);
                last_next = !burst_is_write_reg && final_burst;
            end
            EMIT_DATA:
            begin
                word_next = WORD_W'(burst_data_reg[data_idx_reg]);
                last_next = !data_more && final_burst;
            end
            default:
            begin
                word_next = '0;
                last_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            item_addr_reg <= address[ADDR_WIDTH-1:0];
            item_data_reg <= write_data[DATA_WIDTH-1:0];
            item_wr_reg   <= is_write;
            item_more_reg <= more_waiting;
        end
        if (ctrl.word.act == ACT_OPEN)
        begin
            burst_data_reg[0] <= item_data_reg;
        end
        else if (ctrl.word.act == ACT_APPEND)
        begin
            burst_data_reg[burst_count_reg[IDX_W-1:0]] <= item_data_reg;
        end
        if (emit_fire)
        begin
            net_word_reg  <= word_next;
            last_word_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_open_reg     <= 1'b0;
            burst_base_reg     <= '0;
            burst_is_write_reg <= 1'b0;
            burst_count_reg    <= '0;
            data_idx_reg       <= '0;
            next_id_reg        <= '0;
            reopen_reg         <= 1'b0;
            write_code_reg     <= WRITE_CODE_RESET;
            read_code_reg      <= READ_CODE_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_WRITE_CODE))
            begin
                write_code_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_READ_CODE))
            begin
                read_code_reg <= cfg_data;
            end

            case (ctrl.word.act)
                ACT_OPEN:
                begin
                    burst_open_reg     <= 1'b1;
                    burst_base_reg     <= item_addr_reg;
                    burst_is_write_reg <= item_wr_reg;
                    burst_count_reg    <= CNT_W'(1);
                end
                ACT_APPEND:
                begin
                    burst_count_reg <= burst_count_reg + CNT_W'(1);
                end
                ACT_BREAK:
                begin
                    reopen_reg <= 1'b1;
                end
                ACT_CLOSE:
                begin
                    burst_open_reg  <= 1'b0;
                    burst_count_reg <= '0;
                end
                ACT_REOPEN:
                begin
                    reopen_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase

            if (emit_fire && (ctrl.word.emit == EMIT_ID))
            begin
                next_id_reg <= next_id_reg + WORD_W'(1);
            end
            if (emit_fire && (ctrl.word.emit == EMIT_LEN))
            begin
                data_idx_reg <= '0;
            end
            else if (emit_fire && (ctrl.word.emit == EMIT_DATA))
            begin
                data_idx_reg <= data_idx_reg + IDX_W'(1);
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign net_word  = net_word_reg;
    assign last_word = last_word_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_count_reg <= CNT_W'(MAX_BURST))
        else $error("Burst count exceeds the burst limit.");

    a_open_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        burst_open_reg == (burst_count_reg != '0))
        else $error("Open flag and burst count disagree.");

    a_emit_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> burst_open_reg)
        else $error("A word was framed with no burst open.");

    a_id_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (ctrl.word.emit == EMIT_ID))
        |=> (next_id_reg == $past(next_id_reg) + WORD_W'(1)))
        else $error("Transaction id did not advance by one.");

    a_no_stall_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit_fire)
        else $error("A waiting output word was overwritten.");

endmodule

[rtl/burst_coalescing_request_framer_core.sv]
// ----------------------------------------------------------------------------
// Burst coalescing request framer
// Merges runs of consecutive same-direction memory commands into bursts and
// frames each burst as opcode, transaction id, base address, length and,
// for writes, the buffered data words.
//
//   Channel   Signals                                   Direction
//   command   in_valid/in_ready, address, write_data,   in
//             is_write, more_waiting
//   frame     out_valid/out_ready, net_word, last_word  out
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data  in
//
// A microprogram steps one control word per cycle unless a stalled output
// register holds the step counter. A command that opens or extends a burst
// without sending runs wait, dispatch, then open or match and append, then
// check. Sending emits opcode, id, base, length and, for writes, data words,
// one output word per cycle unless the output stalls; a broken run adds the
// break, close and reopen steps. Reset is asynchronous, clears all control
// state and needs no clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
module burst_coalescing_request_framer_core
#(
    parameter int MAX_BURST  = 8,
    parameter int ADDR_WIDTH = 32,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bcrf_pkg::WORD_W-1:0]       address,
    input  logic [bcrf_pkg::WORD_W-1:0]       write_data,
    input  logic                              is_write,
    input  logic                              more_waiting,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcrf_pkg::WORD_W-1:0]       net_word,
    output logic                              last_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcrf_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    assign cfg_ready = 1'b1;
    assign in_ready  = ctrl.word.take_in;

    bcrf_sequencer u_sequencer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    bcrf_datapath
    #(
        .MAX_BURST  (MAX_BURST),
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .in_valid     (in_valid),
        .address      (address),
        .write_data   (write_data),
        .is_write     (is_write),
        .more_waiting (more_waiting),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .status       (status),
        .out_valid    (out_valid),
        .net_word     (net_word),
        .last_word    (last_word)
    );

endmodule
